[hdl/gei_pkg.sv]
// Shared types, command codes and constants for the GPIO edge interrupt dispatch block.
// Used by gei_pin_store, gei_exec and gpio_edge_interrupt_dispatch; depends on nothing.
package gei_pkg;

  localparam int PIN_SLOTS_DEFAULT = 64;
  localparam int PIN_W             = 6;
  localparam int LIMIT_W           = 7;
  localparam int VEC_COUNT         = 5;

  localparam logic [LIMIT_W-1:0] PIN_LIMIT_RESET = 7'd20;

  typedef enum logic [2:0] {
    CMD_MODE    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_DRIVE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_ATTACH  = 3'd4,
    CMD_VECTOR  = 3'd5,
    CMD_ENABLE  = 3'd6,
    CMD_DISABLE = 3'd7
  } cmd_t;

  localparam logic [1:0] MODE_INPUT  = 2'd0;
  localparam logic [1:0] MODE_PULLUP = 2'd2;

  localparam logic [1:0] EDGE_CHANGE  = 2'd1;
  localparam logic [1:0] EDGE_FALLING = 2'd2;
  localparam logic [1:0] EDGE_RISING  = 2'd3;

  // Bit positions in the vector mask.
  localparam int VEC_INT0  = 0;
  localparam int VEC_INT1  = 1;
  localparam int VEC_PORTB = 2;
  localparam int VEC_PORTC = 3;
  localparam int VEC_PORTD = 4;

  localparam logic [2:0] VEC_INDEX_MAX = 3'd4;

  localparam logic [PIN_W-1:0] PIN_INT0    = 6'd2;
  localparam logic [PIN_W-1:0] PIN_INT1    = 6'd3;
  localparam logic [PIN_W-1:0] PORTD_LAST  = 6'd7;
  localparam logic [PIN_W-1:0] PORTB_FIRST = 6'd8;
  localparam logic [PIN_W-1:0] PORTB_LAST  = 6'd13;
  localparam logic [PIN_W-1:0] PORTC_FIRST = 6'd14;
  localparam logic [PIN_W-1:0] PORTC_LAST  = 6'd19;

  // Everything kept for one pin, held as one row of the pin store.
  typedef struct packed {
    logic       level;
    logic [1:0] mode;
    logic       driven;
    logic [1:0] edge_mode;
    logic       handler;
  } pin_row_t;

  typedef struct packed {
    cmd_t             command;
    logic [PIN_W-1:0] pin_index;
    logic             level;
    logic [1:0]       mode_code;
    logic [2:0]       vector_index;
    logic             handler_present;
  } request_t;

  typedef struct packed {
    logic                 level_changed;
    logic                 edge_handler_fired;
    logic [VEC_COUNT-1:0] vector_fire_mask;
    logic                 read_level;
    logic                 read_floating;
  } result_t;

  // State updates produced by one request.
  typedef struct packed {
    logic                 row_we;
    pin_row_t             row;
    logic                 global_enable;
    logic [VEC_COUNT-1:0] vector_mask;
  } update_t;

  function automatic logic [VEC_COUNT-1:0] vectors_for_pin(input logic [PIN_W-1:0] pin);
    logic [VEC_COUNT-1:0] m;
    m = '0;
    m[VEC_INT0]  = (pin == PIN_INT0);
    m[VEC_INT1]  = (pin == PIN_INT1);
    m[VEC_PORTD] = (pin <= PORTD_LAST);
    m[VEC_PORTB] = (pin >= PORTB_FIRST) && (pin <= PORTB_LAST);
    m[VEC_PORTC] = (pin >= PORTC_FIRST) && (pin <= PORTC_LAST);
    return m;
  endfunction

endpackage

[hdl/gei_pin_store.sv]
// Per-pin row store: one write port, one registered read port, per-row valid bits
// and a bypass of the most recent write. Depends on gei_pkg.
module gei_pin_store #(
  parameter int PIN_SLOTS = gei_pkg::PIN_SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [gei_pkg::PIN_W-1:0] rd_pin,
  input  logic                     wr_en,
  input  logic [gei_pkg::PIN_W-1:0] wr_pin,
  input  gei_pkg::pin_row_t        wr_row,
  output gei_pkg::pin_row_t        row_out
);
  import gei_pkg::*;

  localparam int IDX_W = $clog2(PIN_SLOTS);

  pin_row_t             mem [PIN_SLOTS];
  logic [PIN_SLOTS-1:0] row_valid;

  pin_row_t         rd_data;
  logic             rd_valid;
  logic [PIN_W-1:0] rd_pin_q;

  logic             wb_valid;
  logic [PIN_W-1:0] wb_pin;
  pin_row_t         wb_row;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             rd_in_range;

  assign rd_idx      = rd_pin[IDX_W-1:0];
  assign wr_idx      = wr_pin[IDX_W-1:0];
  assign rd_in_range = ({1'b0, rd_pin} < (PIN_W+1)'(PIN_SLOTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      rd_data  <= rd_in_range ? mem[rd_idx] : '0;
      rd_pin_q <= rd_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      wb_pin    <= '0;
      wb_row    <= '0;
    end else begin
      if (wr_en) begin
        row_valid[wr_idx] <= 1'b1;
        wb_valid          <= 1'b1;
        wb_pin            <= wr_pin;
        wb_row            <= wr_row;
      end
      if (rd_en) begin
        rd_valid <= rd_in_range && row_valid[rd_idx];
      end
    end
  end

  // A write landing on the same edge as the read is only visible through the bypass.
  always_comb begin
    if (wb_valid && (wb_pin == rd_pin_q)) begin
      row_out = wb_row;
    end else if (rd_valid) begin
      row_out = rd_data;
    end else begin
      row_out = '0;
    end
  end

endmodule

[hdl/gei_exec.sv]
// Command execution: decodes one request against its pin row and the global state,
// giving the result and the state updates. Depends on gei_pkg.
module gei_exec #(
  parameter int PIN_SLOTS = gei_pkg::PIN_SLOTS_DEFAULT
) (
  input  gei_pkg::request_t                req,
  input  gei_pkg::pin_row_t                row,
  input  logic [gei_pkg::LIMIT_W-1:0]      pin_limit,
  input  logic                             global_enable,
  input  logic [gei_pkg::VEC_COUNT-1:0]    vector_mask,
  output gei_pkg::result_t                 res,
  output gei_pkg::update_t                 upd
);
  import gei_pkg::*;

  logic                 pin_ok;
  logic                 edge_hit;
  logic [VEC_COUNT-1:0] vec_bit;

  assign pin_ok = ({1'b0, req.pin_index} < pin_limit) &&
                  ({1'b0, req.pin_index} < LIMIT_W'(PIN_SLOTS));

  assign vec_bit = VEC_COUNT'(1) << req.vector_index;

  assign edge_hit = (row.edge_mode == EDGE_CHANGE) ||
                    ((row.edge_mode == EDGE_RISING) && req.level) ||
                    ((row.edge_mode == EDGE_FALLING) && !req.level);

  always_comb begin
    res               = '0;
    upd.row_we        = 1'b0;
    upd.row           = row;
    upd.global_enable = global_enable;
    upd.vector_mask   = vector_mask;

    unique case (req.command)
      CMD_MODE: begin
        upd.row_we   = pin_ok;
        upd.row.mode = req.mode_code;
        if (req.mode_code == MODE_PULLUP) begin
          upd.row.level = 1'b1;
        end
      end
      CMD_WRITE, CMD_DRIVE: begin
        upd.row_we    = pin_ok;
        upd.row.level = req.level;
        if (req.command == CMD_DRIVE) begin
          upd.row.driven = 1'b1;
        end
        if (pin_ok && (row.level != req.level)) begin
          res.level_changed = 1'b1;
          if (global_enable) begin
            res.edge_handler_fired = row.handler && edge_hit;
            res.vector_fire_mask   = vectors_for_pin(req.pin_index) & vector_mask;
          end
        end
      end
      CMD_READ: begin
        if (pin_ok) begin
          res.read_level    = row.level;
          res.read_floating = (row.mode == MODE_INPUT) && !row.driven;
        end
      end
      CMD_ATTACH: begin
        upd.row_we        = pin_ok;
        upd.row.handler   = req.handler_present;
        upd.row.edge_mode = req.mode_code;
      end
      CMD_VECTOR: begin
        if (req.vector_index <= VEC_INDEX_MAX) begin
          if (req.handler_present) begin
            upd.vector_mask = vector_mask | vec_bit;
          end else begin
            upd.vector_mask = vector_mask & ~vec_bit;
          end
        end
      end
      CMD_ENABLE: begin
        upd.global_enable = 1'b1;
      end
      CMD_DISABLE: begin
        upd.global_enable = 1'b0;
      end
    endcase
  end

endmodule

[hdl/gpio_edge_interrupt_dispatch.sv]
// Top level of the GPIO edge interrupt dispatch block: request register, pin store,
// command execution and result register. Depends on gei_pkg, gei_pin_store and gei_exec.
//
// Each request (set mode, write, external drive, read, attach edge handler, register
// vector handler, enable or disable interrupts) yields exactly one result. The block
// takes one request every cycle when the result side keeps up. A result is loaded into
// the result register when its request leaves the request register, which waits while
// the result register is full and not being drained. The pin store's read data is
// registered: the request is held in the request register while its pin row is read,
// then executed and written back on the edge that loads the result register. A
// write-back on the same edge as the next request's read is forwarded through a bypass,
// so back-to-back requests to one pin see each other's effects. Every pin row has a
// valid bit cleared by reset, so no clearing pass is needed and the block is ready in
// the first cycle after reset. The pin limit register (reset value twenty) is written
// through cfg_we and cfg_data and should only change while no request is in flight.
module gpio_edge_interrupt_dispatch #(
  parameter int PIN_SLOTS = gei_pkg::PIN_SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gei_pkg::LIMIT_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     command,
  input  logic [gei_pkg::PIN_W-1:0]      pin_index,
  input  logic                           level,
  input  logic [1:0]                     mode_code,
  input  logic [2:0]                     vector_index,
  input  logic                           handler_present,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           level_changed,
  output logic                           edge_handler_fired,
  output logic [gei_pkg::VEC_COUNT-1:0]  vector_fire_mask,
  output logic                           read_level,
  output logic                           read_floating
);
  import gei_pkg::*;

  logic [LIMIT_W-1:0]   pin_limit;
  logic                 global_enable;
  logic [VEC_COUNT-1:0] vector_mask;

  logic     s1_valid;
  request_t s1_req;
  logic     accept;
  logic     advance;

  pin_row_t row;
  result_t  res;
  update_t  upd;

  // The request register moves on whenever the result register is empty or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_limit <= PIN_LIMIT_RESET;
    end else if (cfg_we) begin
      pin_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req.command         <= cmd_t'(command);
      s1_req.pin_index       <= pin_index;
      s1_req.level           <= level;
      s1_req.mode_code       <= mode_code;
      s1_req.vector_index    <= vector_index;
      s1_req.handler_present <= handler_present;
    end
  end

  gei_pin_store #(
    .PIN_SLOTS (PIN_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_pin  (pin_index),
    .wr_en   (advance && upd.row_we),
    .wr_pin  (s1_req.pin_index),
    .wr_row  (upd.row),
    .row_out (row)
  );

  gei_exec #(
    .PIN_SLOTS (PIN_SLOTS)
  ) u_exec (
    .req           (s1_req),
    .row           (row),
    .pin_limit     (pin_limit),
    .global_enable (global_enable),
    .vector_mask   (vector_mask),
    .res           (res),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      global_enable <= 1'b1;
      vector_mask   <= '0;
    end else if (advance) begin
      global_enable <= upd.global_enable;
      vector_mask   <= upd.vector_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level_changed      <= res.level_changed;
      edge_handler_fired <= res.edge_handler_fired;
      vector_fire_mask   <= res.vector_fire_mask;
      read_level         <= res.read_level;
      read_floating      <= res.read_floating;
    end
  end

`ifndef SYNTHESIS
  // A handler can only fire on a write that actually changed the level.
  a_fire_needs_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_handler_fired |-> level_changed)
    else $error("edge handler fired without a level change");

  a_vector_needs_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && (vector_fire_mask != '0) |-> level_changed)
    else $error("vector fired without a level change");

  // Read results and write results never appear together.
  a_read_write_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_level || read_floating) |-> !level_changed)
    else $error("read and write results mixed in one result");

  a_disable_takes: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_req.command == CMD_DISABLE) |=> !global_enable)
    else $error("disable request did not clear the global enable");
`endif

endmodule

[sim/gei_result_checker.sv]
// Result checker for the GPIO edge interrupt dispatch block: keeps its own copy of the
// pin store, predicts one result per accepted request and compares results in order.
// Depends on gei_pkg for the request and result types and the command codes.
module gei_result_checker #(
  parameter int PIN_SLOTS = gei_pkg::PIN_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gei_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [2:0]                    command,
  input  logic [gei_pkg::PIN_W-1:0]     pin_index,
  input  logic                          level,
  input  logic [1:0]                    mode_code,
  input  logic [2:0]                    vector_index,
  input  logic                          handler_present,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          level_changed,
  input  logic                          edge_handler_fired,
  input  logic [gei_pkg::VEC_COUNT-1:0] vector_fire_mask,
  input  logic                          read_level,
  input  logic                          read_floating,
  output int                            mismatches,
  output int                            outstanding
);
  import gei_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  pin_row_t             pins_q [PIN_SLOTS];
  logic [VEC_COUNT-1:0] vector_mask_q;
  logic                 irq_enable_q;
  logic [LIMIT_W-1:0]   limit_q;
  result_t              expected_q [$];
  result_t              want;
  request_t             req;

  // Applies one request to the shadow pin store and returns the result it should give.
  function automatic result_t apply_request(request_t r);
    result_t              res;
    pin_row_t             row;
    logic                 pin_ok;
    logic [VEC_COUNT-1:0] hits;
    int unsigned          p;
    res    = '0;
    hits   = '0;
    p      = r.pin_index;
    pin_ok = (p < limit_q) && (p < PIN_SLOTS);
    row    = pin_ok ? pins_q[p] : '0;
    case (r.command)
      CMD_MODE: if (pin_ok) begin
        row.mode = r.mode_code;
        if (r.mode_code == MODE_PULLUP) row.level = 1'b1;
      end
      CMD_WRITE, CMD_DRIVE: if (pin_ok) begin
        if (r.command == CMD_DRIVE) row.driven = 1'b1;
        if (row.level != r.level) begin
          res.level_changed = 1'b1;
          if (irq_enable_q) begin
            case (row.edge_mode)
              EDGE_CHANGE:  res.edge_handler_fired = row.handler;
              EDGE_RISING:  res.edge_handler_fired = row.handler && r.level;
              EDGE_FALLING: res.edge_handler_fired = row.handler && !r.level;
              default:      res.edge_handler_fired = 1'b0;
            endcase
            if (r.pin_index == PIN_INT0) hits[VEC_INT0] = 1'b1;
            if (r.pin_index == PIN_INT1) hits[VEC_INT1] = 1'b1;
            if (r.pin_index <= PORTD_LAST) hits[VEC_PORTD] = 1'b1;
            else if (r.pin_index <= PORTB_LAST) hits[VEC_PORTB] = 1'b1;
            else if (r.pin_index <= PORTC_LAST) hits[VEC_PORTC] = 1'b1;
            res.vector_fire_mask = hits & vector_mask_q;
          end
        end
        row.level = r.level;
      end
      CMD_READ: if (pin_ok) begin
        res.read_level    = row.level;
        res.read_floating = (row.mode == MODE_INPUT) && !row.driven;
      end
      CMD_ATTACH: if (pin_ok) begin
        row.handler   = r.handler_present;
        row.edge_mode = r.mode_code;
      end
      CMD_VECTOR: if (r.vector_index <= VEC_INDEX_MAX) begin
        vector_mask_q[r.vector_index] = r.handler_present;
      end
      CMD_ENABLE:  irq_enable_q = 1'b1;
      CMD_DISABLE: irq_enable_q = 1'b0;
      default:     irq_enable_q = irq_enable_q;
    endcase
    if (pin_ok) pins_q[p] = row;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [VEC_COUNT-1:0] want_v,
                             input logic [VEC_COUNT-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pins_q[i]) pins_q[i] = '0;
      vector_mask_q = '0;
      irq_enable_q  = 1'b1;
      limit_q       = PIN_LIMIT_RESET;
      mismatches    = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) limit_q = cfg_data;
      // Results are retired before the request of this edge is queued.
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          check_field("level_changed", want.level_changed, level_changed);
          check_field("edge_handler_fired", want.edge_handler_fired, edge_handler_fired);
          check_field("vector_fire_mask", want.vector_fire_mask, vector_fire_mask);
          check_field("read_level", want.read_level, read_level);
          check_field("read_floating", want.read_floating, read_floating);
        end
      end
      if (in_valid && in_ready) begin
        req.command         = cmd_t'(command);
        req.pin_index       = pin_index;
        req.level           = level;
        req.mode_code       = mode_code;
        req.vector_index    = vector_index;
        req.handler_present = handler_present;
        expected_q.push_back(apply_request(req));
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

[sim/gpio_edge_interrupt_dispatch_tb.sv]
// Testbench top for the GPIO edge interrupt dispatch block: clock, reset, request and
// pin limit stimulus, result-side back-pressure and the final verdict.
// Depends on gei_pkg, gpio_edge_interrupt_dispatch and gei_result_checker.
module gpio_edge_interrupt_dispatch_tb;
  import gei_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIN_SLOTS      = PIN_SLOTS_DEFAULT;
  localparam int TIMEOUT_CYCLES = 200000;
  // Idle cycles run after the last outstanding result has been collected.
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_GAP        = 4;
  localparam int PHASES         = 6;

  // Codes that the package does not name.
  localparam logic [1:0] MODE_OUTPUT   = 2'd1;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [1:0] EDGE_LOW      = 2'd0;
  localparam logic [2:0] VEC_INDEX_TOP = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           command = CMD_READ;
  logic [PIN_W-1:0]     pin_index = '0;
  logic                 level = 1'b0;
  logic [1:0]           mode_code = '0;
  logic [2:0]           vector_index = '0;
  logic                 handler_present = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 level_changed;
  logic                 edge_handler_fired;
  logic [VEC_COUNT-1:0] vector_fire_mask;
  logic                 read_level;
  logic                 read_floating;

  int mismatches;
  int outstanding;
  int cycle_count   = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 48;
  // The stimulus bumps hold_token to ask the result side for one long hold-off.
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  gpio_edge_interrupt_dispatch #(.PIN_SLOTS(PIN_SLOTS)) u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .pin_index          (pin_index),
    .level              (level),
    .mode_code          (mode_code),
    .vector_index       (vector_index),
    .handler_present    (handler_present),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .level_changed      (level_changed),
    .edge_handler_fired (edge_handler_fired),
    .vector_fire_mask   (vector_fire_mask),
    .read_level         (read_level),
    .read_floating      (read_floating)
  );

  gei_result_checker #(.PIN_SLOTS(PIN_SLOTS)) u_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .pin_index          (pin_index),
    .level              (level),
    .mode_code          (mode_code),
    .vector_index       (vector_index),
    .handler_present    (handler_present),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .level_changed      (level_changed),
    .edge_handler_fired (edge_handler_fired),
    .vector_fire_mask   (vector_fire_mask),
    .read_level         (read_level),
    .read_floating      (read_floating),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. Normally it drops ready at random; on request it holds ready low for a
  // long stretch so that the block fills up and has to refuse further requests.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request, possibly after a short idle gap, and returns just after the edge
  // at which it is accepted. Valid is left high so that the next request follows at once.
  task automatic send_request(input cmd_t cmd, input logic [PIN_W-1:0] pin,
                              input logic lvl, input logic [1:0] code,
                              input logic [2:0] vec, input logic hp);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(MAX_GAP, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    pin_index       <= pin;
    level           <= lvl;
    mode_code       <= code;
    vector_index    <= vec;
    handler_present <= hp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The pin limit may only change with nothing in flight, so the request channel is
  // closed and every outstanding result collected before the write.
  task automatic write_pin_limit(input int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= LIMIT_W'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int               limit_plan [PHASES];
    int               items_plan [PHASES];
    int               sel;
    cmd_t             cmd;
    logic [PIN_W-1:0] pin;

    // Pin limits per phase: full width, a single pin, none, above the slot count, the
    // reset value again and finally a random board size.
    limit_plan = '{64, 1, 0, 127, 20, 0};
    limit_plan[PHASES-1] = $urandom_range(63, 2);
    items_plan = '{80, 30, 30, 80, 80, 80};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset pin limit of twenty.
    send_request(CMD_READ, 6'd0, 1'b0, MODE_INPUT, 3'd0, 1'b0);        // floating input
    send_request(CMD_MODE, 6'd4, 1'b0, MODE_RESERVED, 3'd0, 1'b0);
    send_request(CMD_READ, 6'd4, 1'b0, MODE_INPUT, 3'd0, 1'b0);        // not floating
    for (int v = 0; v <= int'(VEC_INDEX_MAX); v++)
      send_request(CMD_VECTOR, 6'd0, 1'b0, MODE_INPUT, 3'(v), 1'b1);
    // An index above the last vector must not clear anything.
    send_request(CMD_VECTOR, 6'd0, 1'b0, MODE_INPUT, VEC_INDEX_TOP, 1'b0);
    send_request(CMD_ATTACH, PIN_INT0, 1'b0, EDGE_CHANGE, 3'd0, 1'b1);
    send_request(CMD_WRITE, PIN_INT0, 1'b1, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_ATTACH, PIN_INT1, 1'b0, EDGE_RISING, 3'd0, 1'b1);
    send_request(CMD_DRIVE, PIN_INT1, 1'b1, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_DRIVE, PIN_INT1, 1'b0, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_ATTACH, PORTB_FIRST + 6'd1, 1'b0, EDGE_FALLING, 3'd0, 1'b1);
    send_request(CMD_WRITE, PORTB_FIRST + 6'd1, 1'b1, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_WRITE, PORTB_FIRST + 6'd1, 1'b0, MODE_INPUT, 3'd0, 1'b0);
    // Low edge mode with a handler attached never fires.
    send_request(CMD_ATTACH, PORTC_FIRST + 6'd1, 1'b0, EDGE_LOW, 3'd0, 1'b1);
    send_request(CMD_WRITE, PORTC_FIRST + 6'd1, 1'b1, MODE_INPUT, 3'd0, 1'b0);
    // Pull-up raises the level quietly, so writing a one afterwards changes nothing.
    send_request(CMD_MODE, PORTC_LAST, 1'b0, MODE_PULLUP, 3'd0, 1'b0);
    send_request(CMD_WRITE, PORTC_LAST, 1'b1, MODE_OUTPUT, 3'd0, 1'b0);
    // With interrupts disabled the change is still reported but nothing fires.
    send_request(CMD_DISABLE, 6'd0, 1'b0, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_WRITE, PIN_INT0, 1'b0, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_ENABLE, 6'd0, 1'b0, MODE_INPUT, 3'd0, 1'b0);
    // Pins at and beyond the limit are ignored.
    send_request(CMD_WRITE, PORTC_LAST + 6'd1, 1'b1, MODE_INPUT, 3'd0, 1'b0);
    send_request(CMD_READ, 6'd63, 1'b0, MODE_INPUT, 3'd0, 1'b0);

    // Random phases. Sender gaps go from light to heavy as result-side idling eases, then
    // both stop altogether; the long result hold-off falls in the first idle-free phase.
    for (int s = 0; s < PHASES; s++) begin
      if (s / 2 == 0) begin
        send_idle_pct <= 32;
        recv_idle_pct <= 48;
      end else if (s / 2 == 1) begin
        send_idle_pct <= 48;
        recv_idle_pct <= 32;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      write_pin_limit(limit_plan[s]);
      if (s == 4) hold_token <= hold_token + 1;
      for (int n = 0; n < items_plan[s]; n++) begin
        // Writes and drives dominate so that edges and vectors actually get exercised.
        sel = $urandom_range(99);
        if (sel < 30)      cmd = CMD_WRITE;
        else if (sel < 50) cmd = CMD_DRIVE;
        else if (sel < 65) cmd = CMD_READ;
        else if (sel < 75) cmd = CMD_ATTACH;
        else if (sel < 84) cmd = CMD_VECTOR;
        else if (sel < 92) cmd = CMD_MODE;
        else if (sel < 97) cmd = CMD_ENABLE;
        else               cmd = CMD_DISABLE;
        // Mostly the mapped pins and the first two past them; now and then any slot.
        if ($urandom_range(9) < 7) pin = PIN_W'($urandom_range(int'(PORTC_LAST) + 2));
        else                       pin = PIN_W'($urandom_range(63));
        send_request(cmd, pin, 1'($urandom_range(1)), 2'($urandom_range(3)),
                     3'($urandom_range(7)), 1'($urandom_range(3) != 0));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/gei_pkg.sv
hdl/gei_pin_store.sv
hdl/gei_exec.sv
hdl/gpio_edge_interrupt_dispatch.sv
sim/gei_result_checker.sv
sim/gpio_edge_interrupt_dispatch_tb.sv
